[src/f16tc_pkg.sv]
// shared constants, types and decode functions for the half-precision tolerance checker
package f16tc_pkg;

  // field widths
  localparam int unsigned HalfW    = 16;
  localparam int unsigned ExpW     = 5;
  localparam int unsigned FracW    = 10;
  localparam int unsigned MantW    = FracW + 1;
  localparam int unsigned ShiftW   = 5;
  localparam int unsigned ValW     = 40;
  localparam int unsigned ErrW     = ValW + 1;
  localparam int unsigned AbsW     = 40;
  localparam int unsigned RelW     = 25;
  localparam int unsigned ProdW    = RelW + MantW;
  localparam int unsigned LimW     = ErrW + 1;
  localparam int unsigned UlpW     = 16;
  localparam int unsigned OrdW     = 17;
  localparam int unsigned IdxW     = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 40;

  // q1.24 relative tolerance
  localparam logic [ShiftW-1:0] REL_FRAC_BITS = 5'd24;

  localparam logic [ExpW-1:0] EXP_ALL_ONES = 5'h1f;
  localparam logic [OrdW-1:0] ORD_BIAS     = 17'h08000;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [1:0]       verdict_t;

  localparam verdict_t VERDICT_MATCH     = 2'd0;
  localparam verdict_t VERDICT_NONFINITE = 2'd1;
  localparam verdict_t VERDICT_MISMATCH  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ABS_TOL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_REL_TOL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ULP = 2'd2;

  // exponent field is not all ones
  function automatic logic half_finite(input half_t b);
    return b[HalfW-2 -: ExpW] != EXP_ALL_ONES;
  endfunction

  // significand with hidden bit for normals
  function automatic logic [MantW-1:0] half_mant(input half_t b);
    logic [ExpW-1:0] e;
    e = b[HalfW-2 -: ExpW];
    return {(e != '0), b[FracW-1:0]};
  endfunction

  // scale of the significand in units of 2^-24
  function automatic logic [ShiftW-1:0] half_shift(input half_t b);
    logic [ExpW-1:0] e;
    e = b[HalfW-2 -: ExpW];
    return (e == '0) ? '0 : ShiftW'(e - 5'd1);
  endfunction

  // monotonic ordering key of a bit pattern
  function automatic logic [OrdW-1:0] half_order(input half_t b);
    if (b[HalfW-1]) begin
      return ORD_BIAS - {2'b00, b[HalfW-2:0]};
    end else begin
      return ORD_BIAS + {1'b0, b};
    end
  endfunction

endpackage

[src/f16tc_pair_if.sv]
// input channel: one expected/actual pair per beat
interface f16tc_pair_if
  import f16tc_pkg::*;
;
  logic  valid;
  logic  ready;
  half_t expected_bits;
  half_t actual_bits;
  logic  last_in;

  modport source (output valid, output expected_bits, output actual_bits, output last_in,
                  input ready);
  modport sink   (input valid, input expected_bits, input actual_bits, input last_in,
                  output ready);
endinterface

[src/f16tc_result_if.sv]
// output channel: one verdict per beat
interface f16tc_result_if
  import f16tc_pkg::*;
;
  logic                valid;
  logic                ready;
  verdict_t            verdict;
  logic [IdxW-1:0]     element_index;
  logic [UlpW-1:0]     ulp_distance;
  logic                last_out;

  modport source (output valid, output verdict, output element_index, output ulp_distance,
                  output last_out, input ready);
  modport sink   (input valid, input verdict, input element_index, input ulp_distance,
                  input last_out, output ready);
endinterface

[src/f16_tolerance_checker_core.sv]
// top level: half-precision tolerance checker, two-register pipeline
//
// pairs carries one expected/actual binary16 pair per beat with a last mark;
// results carries one beat per pair: verdict (match, non-finite operand or
// outside tolerance), the element position within its tensor, the ordered
// ulp distance and the copied last mark.
// the cfg write port (cfg_we, cfg_index, cfg_wdata) sets the absolute
// tolerance, the q1.24 relative tolerance and the ulp limit; write it only
// while no beat is in flight.
// an accepted pair goes through the input register, then the result register; one pair is
// taken every cycle while no stalled result holds the pipeline, the input register feeding a
// single pass of decode, a 25x11 multiply, an add and compares into the result register.
// a stalled result holds in the output register while the input register
// still takes one more pair; further pairs wait on pairs.ready.
// reset clears the tolerances, the element counter and both valid flags.
module f16_tolerance_checker_core
  import f16tc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  f16tc_pair_if.sink           pairs,
  f16tc_result_if.source       results,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata
);

  // configuration registers
  logic [AbsW-1:0] abs_tolerance;
  logic [RelW-1:0] rel_tolerance;
  logic [UlpW-1:0] max_ulp;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_tolerance <= '0;
      rel_tolerance <= '0;
      max_ulp       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ABS_TOL: abs_tolerance <= cfg_wdata[AbsW-1:0];
        CFG_REL_TOL: rel_tolerance <= cfg_wdata[RelW-1:0];
        CFG_MAX_ULP: max_ulp       <= cfg_wdata[UlpW-1:0];
        default:     ;
      endcase
    end
  end

  // pipeline handshake
  logic in_v;
  logic out_v;
  logic out_load;
  logic pair_beat;

  assign out_load    = !out_v || results.ready;
  assign pairs.ready = !in_v || out_load;
  assign pair_beat   = pairs.valid && pairs.ready;

  // element counter
  logic [IdxW-1:0] elem_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else if (pair_beat) begin
      elem_count <= pairs.last_in ? '0 : elem_count + 1'b1;
    end
  end

  // input register
  half_t           in_exp;
  half_t           in_act;
  logic            in_last;
  logic [IdxW-1:0] in_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (pairs.ready) begin
      in_v <= pairs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_beat) begin
      in_exp  <= pairs.expected_bits;
      in_act  <= pairs.actual_bits;
      in_last <= pairs.last_in;
      in_idx  <= elem_count;
    end
  end

  // ordered distance
  logic [OrdW-1:0] ord_e;
  logic [OrdW-1:0] ord_a;
  logic [OrdW-1:0] ulp_full;

  assign ord_e    = half_order(in_exp);
  assign ord_a    = half_order(in_act);
  assign ulp_full = (ord_e > ord_a) ? ord_e - ord_a : ord_a - ord_e;

  // fixed-point decode in units of 2^-24
  logic [MantW-1:0]  mant_e;
  logic [MantW-1:0]  mant_a;
  logic [ShiftW-1:0] shift_e;
  logic [ShiftW-1:0] shift_a;
  logic [ValW-1:0]   val_e;
  logic [ValW-1:0]   val_a;
  logic              neg_e;
  logic              neg_a;

  assign mant_e  = half_mant(in_exp);
  assign mant_a  = half_mant(in_act);
  assign shift_e = half_shift(in_exp);
  assign shift_a = half_shift(in_act);
  assign val_e   = ValW'(mant_e) << shift_e;
  assign val_a   = ValW'(mant_a) << shift_a;
  // negative zero counts as zero
  assign neg_e   = in_exp[HalfW-1] && (in_exp[HalfW-2:0] != '0);
  assign neg_a   = in_act[HalfW-1] && (in_act[HalfW-2:0] != '0);

  // absolute error
  logic [ErrW-1:0] abs_err;

  always_comb begin
    if (neg_e == neg_a) begin
      abs_err = (val_e > val_a) ? ErrW'(val_e - val_a) : ErrW'(val_a - val_e);
    end else begin
      abs_err = ErrW'(val_e) + ErrW'(val_a);
    end
  end

  // relative allowance, rounded down
  logic [ProdW-1:0] rel_prod;
  logic [ErrW-1:0]  rel_prod_ext;
  logic [ErrW-1:0]  rel_part;
  logic [LimW-1:0]  err_limit;

  assign rel_prod     = ProdW'(rel_tolerance) * ProdW'(mant_e);
  assign rel_prod_ext = ErrW'(rel_prod);

  always_comb begin
    if (shift_e >= REL_FRAC_BITS) begin
      rel_part = rel_prod_ext << (shift_e - REL_FRAC_BITS);
    end else begin
      rel_part = rel_prod_ext >> (REL_FRAC_BITS - shift_e);
    end
  end

  assign err_limit = LimW'(abs_tolerance) + LimW'(rel_part);

  // verdict
  verdict_t verdict_next;
  logic     both_finite;
  logic     same_value;

  assign both_finite = half_finite(in_exp) && half_finite(in_act);
  assign same_value  = (val_e == val_a) && (neg_e == neg_a);

  always_comb begin
    priority if (!both_finite) begin
      verdict_next = VERDICT_NONFINITE;
    end else if (same_value) begin
      verdict_next = VERDICT_MATCH;
    end else if ((LimW'(abs_err) <= err_limit) && (ulp_full <= OrdW'(max_ulp))) begin
      verdict_next = VERDICT_MATCH;
    end else begin
      verdict_next = VERDICT_MISMATCH;
    end
  end

  // result register
  verdict_t        out_verdict;
  logic [IdxW-1:0] out_idx;
  logic [UlpW-1:0] out_ulp;
  logic            out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_load) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_v) begin
      out_verdict <= verdict_next;
      out_idx     <= in_idx;
      out_ulp     <= ulp_full[UlpW-1:0];
      out_last    <= in_last;
    end
  end

  assign results.valid         = out_v;
  assign results.verdict       = out_verdict;
  assign results.element_index = out_idx;
  assign results.ulp_distance  = out_ulp;
  assign results.last_out      = out_last;

`ifndef SYNTH
  // a full pipeline behind a stalled result takes no pair
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_v && out_v && !results.ready) |-> !pairs.ready)
    else $error("pair taken while pipeline full and stalled");

  // a last-marked pair restarts the element count
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (pair_beat && pairs.last_in) |=> (elem_count == '0))
    else $error("element counter did not restart after last beat");

  // identical finite patterns always match
  a_equal_match: assert property (@(posedge clk) disable iff (rst)
    (in_v && (in_exp == in_act) && both_finite) |-> (verdict_next == VERDICT_MATCH))
    else $error("identical finite pair not matched");

  // a result beat never carries an undefined verdict code
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_verdict == VERDICT_MATCH || out_verdict == VERDICT_NONFINITE ||
               out_verdict == VERDICT_MISMATCH))
    else $error("undefined verdict code on result");
`endif

endmodule

[dv/f16_tolerance_checker_core_tb.sv]
// testbench for f16_tolerance_checker_core: directed and random pairs checked against a predictor
module f16_tolerance_checker_core_tb;
  import f16tc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam int EXP_LSB = FracW;
  localparam half_t SIGN_MASK = 16'h8000;
  localparam half_t MAG_MASK  = 16'h7fff;
  localparam half_t FRAC_MASK = 16'h03ff;
  localparam logic [MantW-1:0] HIDDEN_ONE = 11'h400;
  localparam logic [AbsW-1:0] ABS_MAX = 40'hff_ffff_ffff;
  localparam logic [RelW-1:0] REL_MAX = 25'h1ff_ffff;
  localparam logic [RelW-1:0] REL_ONE = 25'h100_0000;
  localparam logic [UlpW-1:0] ULP_MAX = 16'hffff;

  typedef struct packed {
    verdict_t        verdict;
    logic [IdxW-1:0] index;
    logic [UlpW-1:0] ulp;
    logic            last;
  } verdict_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  f16tc_pair_if   pairs_bus();
  f16tc_result_if results_bus();

  f16_tolerance_checker_core u_top (
    .clk       (clk),
    .rst       (rst),
    .pairs     (pairs_bus),
    .results   (results_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow registers and element position
  logic [AbsW-1:0] abs_tol_q;
  logic [RelW-1:0] rel_tol_q;
  logic [UlpW-1:0] ulp_lim_q;
  logic [IdxW-1:0] tensor_pos;

  verdict_beat_t pending_verdicts[$];
  int errors = 0;

  // idling controls
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;

  // fixed-point magnitude as sig * 2^scale in units of 2^-24
  function automatic void split_half(input half_t b, output logic [MantW-1:0] sig,
                                     output logic [ShiftW-1:0] scale);
    logic [ExpW-1:0] ex;
    ex = b[EXP_LSB +: ExpW];
    if (ex == '0) begin
      sig = MantW'(b & FRAC_MASK);
      scale = '0;
    end else begin
      sig = HIDDEN_ONE | MantW'(b & FRAC_MASK);
      scale = ShiftW'(ex) - ShiftW'(1);
    end
  endfunction

  // monotonic key of a bit pattern
  function automatic logic [OrdW-1:0] order_key(input half_t b);
    return (b & SIGN_MASK) != '0 ? ORD_BIAS - OrdW'(b & MAG_MASK) : ORD_BIAS + OrdW'(b);
  endfunction

  // expected result beat for one pair under the current registers
  function automatic verdict_beat_t judge_pair(input half_t e, input half_t a, input logic last);
    verdict_beat_t beat;
    logic [OrdW-1:0] ke, ka, key_gap;
    logic [MantW-1:0] me, ma;
    logic [ShiftW-1:0] se, sa;
    logic [63:0] ve, va, err, prod, slack, lim;
    logic ne, na;
    ke = order_key(e);
    ka = order_key(a);
    key_gap = (ke > ka) ? ke - ka : ka - ke;
    beat.ulp = key_gap[UlpW-1:0];
    beat.index = tensor_pos;
    beat.last = last;
    if (e[EXP_LSB +: ExpW] == EXP_ALL_ONES || a[EXP_LSB +: ExpW] == EXP_ALL_ONES) begin
      beat.verdict = VERDICT_NONFINITE;
    end else begin
      split_half(e, me, se);
      split_half(a, ma, sa);
      ve = 64'(me) << se;
      va = 64'(ma) << sa;
      ne = e[HalfW-1] && (ve != 0);
      na = a[HalfW-1] && (va != 0);
      if (ve == va && ne == na) begin
        beat.verdict = VERDICT_MATCH;
      end else begin
        if (ne == na) begin
          err = (ve > va) ? ve - va : va - ve;
        end else begin
          err = ve + va;
        end
        // relative part, rounded down
        prod = 64'(rel_tol_q) * 64'(me);
        if (se >= REL_FRAC_BITS) begin
          slack = prod << (se - REL_FRAC_BITS);
        end else begin
          slack = prod >> (REL_FRAC_BITS - se);
        end
        lim = 64'(abs_tol_q) + slack;
        beat.verdict = (err <= lim && beat.ulp <= ulp_lim_q) ? VERDICT_MATCH : VERDICT_MISMATCH;
      end
    end
    return beat;
  endfunction

  // one pair beat; returns at the falling edge after acceptance with valid still high
  task automatic send_pair(input half_t e, input half_t a, input logic last);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      pairs_bus.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_gap_pct) @(negedge clk);
    end
    pairs_bus.valid <= 1'b1;
    pairs_bus.expected_bits <= e;
    pairs_bus.actual_bits <= a;
    pairs_bus.last_in <= last;
    @(posedge clk);
    while (!pairs_bus.ready) @(posedge clk);
    pending_verdicts = {pending_verdicts, judge_pair(e, a, last)};
    tensor_pos = last ? '0 : tensor_pos + 1'b1;
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding verdict
  task automatic wait_results_done();
    pairs_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_ABS_TOL: abs_tol_q = data[AbsW-1:0];
      CFG_REL_TOL: rel_tol_q = data[RelW-1:0];
      CFG_MAX_ULP: ulp_lim_q = data[UlpW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_tolerances(input logic [AbsW-1:0] abs_v, input logic [RelW-1:0] rel_v,
                                input logic [UlpW-1:0] ulp_v);
    wait_results_done();
    write_reg(CFG_ABS_TOL, CfgDataW'(abs_v));
    write_reg(CFG_REL_TOL, CfgDataW'(rel_v));
    write_reg(CFG_MAX_ULP, CfgDataW'(ulp_v));
  endtask

  function automatic half_t special_half(input int k);
    case (k)
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7c00;
      3: return 16'hfc00;
      4: return 16'h7e01;
      5: return 16'h0001;
      6: return 16'h7bff;
      7: return 16'h0400;
      8: return 16'h3c00;
      default: return 16'hffff;
    endcase
  endfunction

  // random pair, weighted toward close values so tolerances decide
  task automatic pick_pair(output half_t e, output half_t a, output logic last);
    int kind;
    kind = $urandom_range(99);
    e = half_t'($urandom);
    if (kind < 30) begin
      a = e + half_t'($urandom_range(6)) - 16'd3;
    end else if (kind < 42) begin
      a = e;
    end else if (kind < 55) begin
      a = (e ^ SIGN_MASK) + half_t'($urandom_range(2)) - 16'd1;
    end else if (kind < 75) begin
      a = half_t'($urandom);
    end else if (kind < 88) begin
      e = special_half($urandom_range(9));
      a = ($urandom_range(1) == 0) ? special_half($urandom_range(9)) : half_t'($urandom);
      if ($urandom_range(1) == 0) begin
        {e, a} = {a, e};
      end
    end else begin
      // subnormal or low-exponent values
      e = half_t'($urandom) & 16'h87ff;
      a = e + half_t'($urandom_range(64)) - 16'd32;
    end
    last = ($urandom_range(15) == 0);
  endtask

  task automatic random_tolerances();
    logic [AbsW-1:0] abs_v;
    logic [CfgDataW-1:0] rel_data;
    logic [UlpW-1:0] ulp_v;
    case ($urandom_range(3))
      0: abs_v = '0;
      1: abs_v = ABS_MAX;
      2: abs_v = AbsW'($urandom_range(1 << 16));
      default: abs_v = {8'($urandom), 32'($urandom)};
    endcase
    case ($urandom_range(4))
      0: rel_data = '0;
      1: rel_data = CfgDataW'(REL_MAX);
      2: rel_data = CfgDataW'(REL_ONE);
      3: rel_data = CfgDataW'($urandom_range(1 << 12));
      default: rel_data = {8'($urandom), 32'($urandom)};
    endcase
    case ($urandom_range(3))
      0: ulp_v = '0;
      1: ulp_v = ULP_MAX;
      2: ulp_v = UlpW'($urandom_range(8));
      default: ulp_v = UlpW'($urandom);
    endcase
    wait_results_done();
    write_reg(CFG_ABS_TOL, CfgDataW'(abs_v));
    write_reg(CFG_REL_TOL, rel_data);
    write_reg(CFG_MAX_ULP, CfgDataW'(ulp_v));
  endtask

  // reset values: zero tolerance, special operands
  task automatic test_reset_defaults();
    send_pair(16'h0000, 16'h8000, 1'b0);
    send_pair(16'h3c00, 16'h3c00, 1'b0);
    send_pair(16'h3c00, 16'h3c01, 1'b0);
    send_pair(16'h7c00, 16'h3c00, 1'b0);
    send_pair(16'h7e00, 16'h7e00, 1'b0);
    send_pair(16'h3c00, 16'hfc00, 1'b0);
    send_pair(16'hffff, 16'h0000, 1'b0);
    send_pair(16'h0001, 16'h8001, 1'b1);
    send_pair(16'h7bff, 16'hfbff, 1'b0);
    send_pair(16'h03ff, 16'h0400, 1'b0);
    send_pair(16'hffff, 16'hffff, 1'b1);
  endtask

  // largest registers, then relative tolerance of exactly one
  task automatic test_tolerance_extremes();
    set_tolerances(ABS_MAX, REL_MAX, ULP_MAX);
    send_pair(16'h7bff, 16'hfbff, 1'b0);
    send_pair(16'h0001, 16'h8001, 1'b0);
    send_pair(16'h3c00, 16'h4000, 1'b0);
    send_pair(16'h7bff, 16'h0000, 1'b1);
    set_tolerances('0, REL_ONE, ULP_MAX);
    send_pair(16'h3c00, 16'h0000, 1'b0);
    send_pair(16'h3c00, 16'h4000, 1'b0);
    send_pair(16'h3c00, 16'h4001, 1'b1);
  endtask

  // ulp limit decides with a wide absolute allowance
  task automatic test_ulp_limit();
    set_tolerances(ABS_MAX, '0, 16'd1);
    send_pair(16'h3c00, 16'h3c01, 1'b0);
    send_pair(16'h3c00, 16'h3c02, 1'b0);
    send_pair(16'h0000, 16'h8001, 1'b0);
    send_pair(16'h8001, 16'h0001, 1'b1);
  endtask

  // a write to the spare index changes nothing
  task automatic test_unused_index();
    set_tolerances('0, '0, '0);
    write_reg(CFG_UNUSED, {CfgDataW{1'b1}});
    send_pair(16'h3c00, 16'h3c01, 1'b0);
    send_pair(16'h4000, 16'h4000, 1'b1);
  endtask

  // random pairs under two register settings for one idling mode
  task automatic test_random_phase(input int gap_pct, input int stall_pct, input int n);
    half_t e, a;
    logic last;
    for (int s = 0; s < 2; s++) begin
      random_tolerances();
      send_gap_pct = gap_pct;
      recv_stall_pct <= stall_pct;
      for (int i = 0; i < n; i++) begin
        pick_pair(e, a, last);
        send_pair(e, a, last);
        // sender pauses for all results midway
        if (i == n / 2) begin
          wait_results_done();
        end
      end
    end
  endtask

  // long receiver hold while pairs keep coming back to back
  task automatic test_backpressure();
    half_t e, a;
    logic last;
    wait_results_done();
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    hold_len <= 250;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 60; i++) begin
      pick_pair(e, a, last);
      send_pair(e, a, last);
    end
  endtask

  // receiver ready, with random stalls and requested holds
  initial begin
    results_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        results_bus.ready <= 1'b0;
      end else begin
        results_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // compare each result beat with the oldest expected verdict
  always @(posedge clk) begin
    verdict_beat_t want;
    if (rst == 1'b0 && results_bus.valid === 1'b1 && results_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual verdict %0d index %0d",
                 $time, results_bus.verdict, results_bus.element_index);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (results_bus.verdict !== want.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, want.verdict,
                   results_bus.verdict);
          errors++;
        end
        if (results_bus.element_index !== want.index) begin
          $display("%0t: element_index expected %0d actual %0d", $time, want.index,
                   results_bus.element_index);
          errors++;
        end
        if (results_bus.ulp_distance !== want.ulp) begin
          $display("%0t: ulp_distance expected %0d actual %0d", $time, want.ulp,
                   results_bus.ulp_distance);
          errors++;
        end
        if (results_bus.last_out !== want.last) begin
          $display("%0t: last_out expected %0d actual %0d", $time, want.last,
                   results_bus.last_out);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    pairs_bus.valid <= 1'b0;
    pairs_bus.expected_bits <= '0;
    pairs_bus.actual_bits <= '0;
    pairs_bus.last_in <= 1'b0;
    abs_tol_q = '0;
    rel_tol_q = '0;
    ulp_lim_q = '0;
    tensor_pos = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_tolerance_extremes();
    test_ulp_limit();
    test_unused_index();
    test_random_phase(0, 0, 170);
    test_random_phase(59, 0, 170);
    test_random_phase(0, 59, 170);
    test_random_phase(29, 29, 170);
    test_backpressure();
    wait_results_done();
    repeat (8) @(negedge clk);

    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
